// ===== hw/rtl/hlcc_pkg.sv =====
// Package for the heartbeat line checker: beat types, result codes and the
// CRC-16/CCITT-FALSE byte update. No dependencies.
`default_nettype none
package hlcc_pkg;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] time_seconds;
  } in_beat_t;

  typedef struct packed {
    logic        heartbeat_ok;
    logic [1:0]  line_kind;
    logic        link_valid;
    logic [31:0] last_rx_ms;
  } out_beat_t;

  // One classified byte handed from the front to the parser.
  typedef struct packed {
    logic        eol;
    logic        feed;
    logic [7:0]  ch;
    logic        is_ws;
    logic        is_dig;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [31:0] secs;
  } char_t;

  localparam logic [1:0] KIND_REJECT = 2'd0;
  localparam logic [1:0] KIND_BARE   = 2'd1;
  localparam logic [1:0] KIND_SHORT  = 2'd2;
  localparam logic [1:0] KIND_CANON  = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = ((r & CRC_MSB) != 16'h0000) ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hlcc_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// Standalone; carries a flat vector of Width bits.
`default_nettype none
module hlcc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/hlcc_front.sv =====
// Front end: line length limit, end-of-text tracking and byte classification.
// Depends on hlcc_pkg.
`default_nettype none
module hlcc_front #(
  parameter int LINE_BYTES = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire hlcc_pkg::in_beat_t beat_i,
  output hlcc_pkg::char_t        char_o
);
  localparam int CntW = $clog2(LINE_BYTES);
  localparam logic [CntW-1:0] LastCnt = CntW'(LINE_BYTES - 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            zero_q, zero_d;
  logic            stored, eol;
  logic [7:0]      ch;

  assign ch     = beat_i.rx_byte;
  assign stored = (cnt_q < LastCnt);
  assign eol    = (ch == hlcc_pkg::CH_NL);

  always_comb begin
    char_o.eol     = eol;
    char_o.feed    = stored && !zero_q && (ch != 8'd0) && !eol;
    char_o.ch      = ch;
    char_o.secs    = beat_i.time_seconds;
    char_o.is_ws   = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    char_o.is_dig  = (ch >= 8'h30 && ch <= 8'h39);
    char_o.is_hex  = 1'b1;
    char_o.hex_val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      char_o.hex_val = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      char_o.hex_val = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      char_o.hex_val = 4'(ch - 8'h37);
    end else begin
      char_o.is_hex = 1'b0;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    zero_d = zero_q;
    if (take_i) begin
      if (eol) begin
        cnt_d  = '0;
        zero_d = 1'b0;
      end else if (stored) begin
        cnt_d = cnt_q + CntW'(1);
        if (ch == 8'd0) begin
          zero_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      zero_q <= zero_d;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/hlcc_back.sv =====
// Back end: streaming parser with running CRC over the reprinted text,
// verdict per line and the sticky link state. Depends on hlcc_pkg.
`default_nettype none
module hlcc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire hlcc_pkg::char_t char_i,
  output logic                 take_o,
  output logic                 res_push_o,
  input  wire logic            res_full_i,
  output hlcc_pkg::out_beat_t  res_o
);
  localparam logic [3:0] PH_H    = 4'd0;
  localparam logic [3:0] PH_B    = 4'd1;
  localparam logic [3:0] PH_SEP  = 4'd2;
  localparam logic [3:0] PH_WS   = 4'd3;
  localparam logic [3:0] PH_SIGN = 4'd4;
  localparam logic [3:0] PH_DIG  = 4'd5;
  localparam logic [3:0] PH_TWS  = 4'd6;
  localparam logic [3:0] PH_TOK  = 4'd7;
  localparam logic [3:0] PH_TEND = 4'd8;
  localparam logic [3:0] PH_DONE = 4'd9;

  localparam logic [2:0] T_FIRST = 3'd0;
  localparam logic [2:0] T_SIGN  = 3'd1;
  localparam logic [2:0] T_ZERO  = 3'd2;
  localparam logic [2:0] T_DIGS  = 3'd3;
  localparam logic [2:0] T_STOP  = 3'd4;

  localparam logic [3:0] TOK_MAX = 4'd15;

  logic [3:0]  ph_q, ph_d;
  logic [1:0]  fld_q, fld_d;
  logic        neg_q, neg_d, big_q, big_d, nz_q, nz_d, dnz_q, dnz_d;
  logic [31:0] mag_q, mag_d;
  logic [15:0] crc_q, crc_d, hv_q, hv_d;
  logic        hneg_q, hneg_d;
  logic [3:0]  tcnt_q, tcnt_d;
  logic [2:0]  tsub_q, tsub_d;
  logic [1:0]  kind_q, kind_d;
  logic        link_q, link_d;
  logic [31:0] last_q, last_d;

  logic [7:0]  ch;
  logic [35:0] prod;
  logic [31:0] mag_dig;
  logic        big_dig, nz_dig, ovf, step, fin;
  logic [15:0] crc_dig, crc_end, crc_end_sep, hv_fin, hv_acc;
  logic [2:0]  sub_in, sub_nx;
  logic [15:0] hv_nx;
  logic        hneg_nx;
  logic [1:0]  kind_term;

  assign ch     = char_i.ch;
  assign take_o = valid_i && (!char_i.eol || !res_full_i);
  assign step   = take_o && char_i.feed;
  assign fin    = take_o && char_i.eol;
  assign res_push_o = fin;

  always_comb begin
    prod    = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {32'd0, char_i.hex_val};
    big_dig = big_q || (prod[35:32] != 4'd0);
    mag_dig = big_q ? mag_q : prod[31:0];
    nz_dig  = nz_q || (char_i.hex_val != 4'd0);
    crc_dig = crc_q;
    if (nz_q) begin
      crc_dig = hlcc_pkg::crc_byte(crc_q, ch);
    end else if (char_i.hex_val != 4'd0) begin
      crc_dig = neg_q ? hlcc_pkg::crc_byte(hlcc_pkg::crc_byte(crc_q, hlcc_pkg::CH_MINUS), ch)
                      : hlcc_pkg::crc_byte(crc_q, ch);
    end
    ovf         = big_q || (neg_q ? (mag_q > 32'h8000_0000) : (mag_q > 32'h7FFF_FFFF));
    crc_end     = nz_q ? crc_q : hlcc_pkg::crc_byte(crc_q, hlcc_pkg::CH_ZERO);
    crc_end_sep = hlcc_pkg::crc_byte(crc_end, hlcc_pkg::CH_COMMA);
  end

  always_comb begin
    sub_in  = (ph_q == PH_TWS) ? T_FIRST : tsub_q;
    hv_acc  = {hv_q[11:0], char_i.hex_val};
    sub_nx  = sub_in;
    hv_nx   = hv_q;
    hneg_nx = hneg_q;
    unique case (sub_in)
      T_FIRST: begin
        if (ch == hlcc_pkg::CH_PLUS || ch == hlcc_pkg::CH_MINUS) begin
          sub_nx  = T_SIGN;
          hneg_nx = (ch == hlcc_pkg::CH_MINUS);
        end else if (ch == hlcc_pkg::CH_ZERO) begin
          sub_nx = T_ZERO;
        end else if (char_i.is_hex) begin
          sub_nx = T_DIGS;
          hv_nx  = hv_acc;
        end else begin
          sub_nx = T_STOP;
        end
      end
      T_SIGN: begin
        if (ch == hlcc_pkg::CH_ZERO) begin
          sub_nx = T_ZERO;
        end else if (char_i.is_hex) begin
          sub_nx = T_DIGS;
          hv_nx  = hv_acc;
        end else begin
          sub_nx = T_STOP;
        end
      end
      T_ZERO: begin
        if (ch == hlcc_pkg::CH_UX || ch == hlcc_pkg::CH_LX) begin
          sub_nx = T_DIGS;
        end else if (char_i.is_hex) begin
          sub_nx = T_DIGS;
          hv_nx  = hv_acc;
        end else begin
          sub_nx = T_STOP;
        end
      end
      T_DIGS: begin
        if (char_i.is_hex) begin
          hv_nx = hv_acc;
        end else begin
          sub_nx = T_STOP;
        end
      end
      default: begin
        sub_nx = T_STOP;
      end
    endcase
  end

  always_comb begin
    hv_fin = hneg_q ? (16'd0 - hv_q) : hv_q;
    unique case (ph_q)
      PH_H, PH_B: kind_term = hlcc_pkg::KIND_REJECT;
      PH_SEP:     kind_term = hlcc_pkg::KIND_BARE;
      PH_WS, PH_SIGN, PH_TWS: kind_term = hlcc_pkg::KIND_SHORT;
      PH_DIG:     kind_term = ovf ? hlcc_pkg::KIND_REJECT : hlcc_pkg::KIND_SHORT;
      PH_TOK, PH_TEND: begin
        kind_term = ((crc_q == hv_fin) && dnz_q) ? hlcc_pkg::KIND_CANON
                                                 : hlcc_pkg::KIND_REJECT;
      end
      default:    kind_term = kind_q;
    endcase
  end

  always_comb begin
    ph_d   = ph_q;
    fld_d  = fld_q;
    neg_d  = neg_q;
    big_d  = big_q;
    nz_d   = nz_q;
    dnz_d  = dnz_q;
    mag_d  = mag_q;
    crc_d  = crc_q;
    hv_d   = hv_q;
    hneg_d = hneg_q;
    tcnt_d = tcnt_q;
    tsub_d = tsub_q;
    kind_d = kind_q;
    link_d = link_q;
    last_d = last_q;
    if (fin) begin
      if (kind_term != hlcc_pkg::KIND_REJECT) begin
        link_d = 1'b1;
        last_d = char_i.secs * 32'd1000;
      end
      ph_d   = PH_H;
      fld_d  = 2'd0;
      neg_d  = 1'b0;
      big_d  = 1'b0;
      nz_d   = 1'b0;
      dnz_d  = 1'b0;
      mag_d  = '0;
      crc_d  = hlcc_pkg::CRC_INIT;
      hv_d   = '0;
      hneg_d = 1'b0;
      tcnt_d = '0;
      tsub_d = T_FIRST;
    end else if (step) begin
      unique case (ph_q)
        PH_H: begin
          if (ch == hlcc_pkg::CH_UH || ch == hlcc_pkg::CH_LH) begin
            crc_d = hlcc_pkg::crc_byte(crc_q, hlcc_pkg::CH_UH);
            ph_d  = PH_B;
          end else begin
            kind_d = hlcc_pkg::KIND_REJECT;
            ph_d   = PH_DONE;
          end
        end
        PH_B: begin
          if (ch == hlcc_pkg::CH_UB || ch == hlcc_pkg::CH_LB) begin
            crc_d = hlcc_pkg::crc_byte(crc_q, hlcc_pkg::CH_UB);
            ph_d  = PH_SEP;
          end else begin
            kind_d = hlcc_pkg::KIND_REJECT;
            ph_d   = PH_DONE;
          end
        end
        PH_SEP: begin
          ph_d = PH_DONE;
          if (ch == hlcc_pkg::CH_CR) begin
            kind_d = hlcc_pkg::KIND_BARE;
          end else if (ch == hlcc_pkg::CH_COMMA) begin
            crc_d = hlcc_pkg::crc_byte(crc_q, hlcc_pkg::CH_COMMA);
            ph_d  = PH_WS;
          end else begin
            kind_d = hlcc_pkg::KIND_REJECT;
          end
        end
        PH_WS, PH_SIGN: begin
          if (char_i.is_dig) begin
            mag_d = mag_dig;
            big_d = big_dig;
            nz_d  = nz_dig;
            crc_d = crc_dig;
            ph_d  = PH_DIG;
          end else if (ph_q == PH_WS && char_i.is_ws) begin
            ph_d = PH_WS;
          end else if (ph_q == PH_WS &&
                       (ch == hlcc_pkg::CH_PLUS || ch == hlcc_pkg::CH_MINUS)) begin
            neg_d = (ch == hlcc_pkg::CH_MINUS);
            ph_d  = PH_SIGN;
          end else begin
            kind_d = hlcc_pkg::KIND_SHORT;
            ph_d   = PH_DONE;
          end
        end
        PH_DIG: begin
          if (char_i.is_dig) begin
            mag_d = mag_dig;
            big_d = big_dig;
            nz_d  = nz_dig;
            crc_d = crc_dig;
          end else if (ovf) begin
            kind_d = hlcc_pkg::KIND_REJECT;
            ph_d   = PH_DONE;
          end else if (ch != hlcc_pkg::CH_COMMA) begin
            kind_d = hlcc_pkg::KIND_SHORT;
            ph_d   = PH_DONE;
          end else if (fld_q == 2'd3) begin
            dnz_d = nz_q;
            crc_d = crc_end;
            ph_d  = PH_TWS;
          end else begin
            crc_d = crc_end_sep;
            fld_d = fld_q + 2'd1;
            neg_d = 1'b0;
            big_d = 1'b0;
            nz_d  = 1'b0;
            mag_d = '0;
            ph_d  = PH_WS;
          end
        end
        PH_TWS: begin
          if (!char_i.is_ws) begin
            tcnt_d = 4'd1;
            tsub_d = sub_nx;
            hv_d   = hv_nx;
            hneg_d = hneg_nx;
            ph_d   = PH_TOK;
          end
        end
        PH_TOK: begin
          if (char_i.is_ws || tcnt_q == TOK_MAX) begin
            ph_d = PH_TEND;
          end else begin
            tcnt_d = tcnt_q + 4'd1;
            tsub_d = sub_nx;
            hv_d   = hv_nx;
            hneg_d = hneg_nx;
          end
        end
        default: begin
          ph_d = ph_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_H;
      fld_q  <= 2'd0;
      neg_q  <= 1'b0;
      big_q  <= 1'b0;
      nz_q   <= 1'b0;
      dnz_q  <= 1'b0;
      mag_q  <= '0;
      crc_q  <= hlcc_pkg::CRC_INIT;
      hv_q   <= '0;
      hneg_q <= 1'b0;
      tcnt_q <= '0;
      tsub_q <= T_FIRST;
      kind_q <= hlcc_pkg::KIND_REJECT;
      link_q <= 1'b0;
      last_q <= '0;
    end else begin
      ph_q   <= ph_d;
      fld_q  <= fld_d;
      neg_q  <= neg_d;
      big_q  <= big_d;
      nz_q   <= nz_d;
      dnz_q  <= dnz_d;
      mag_q  <= mag_d;
      crc_q  <= crc_d;
      hv_q   <= hv_d;
      hneg_q <= hneg_d;
      tcnt_q <= tcnt_d;
      tsub_q <= tsub_d;
      kind_q <= kind_d;
      link_q <= link_d;
      last_q <= last_d;
    end
  end

  always_comb begin
    res_o.heartbeat_ok = (kind_term != hlcc_pkg::KIND_REJECT);
    res_o.line_kind    = kind_term;
    res_o.link_valid   = link_d;
    res_o.last_rx_ms   = last_d;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/heartbeat_line_crc_checker.sv =====
// Heartbeat line checker: one byte beat per cycle in, one verdict beat per line out.
// Each newline beat passes the character queue before the parser writes the verdict
// into the result queue, waiting only while that queue is full.
// Throughput: one byte per cycle while full is low; the parser steps one character.
// Reset clears the line state, the link flag and the recorded time.
// Depends on hlcc_pkg, hlcc_fifo, hlcc_front and hlcc_back.
`default_nettype none
module heartbeat_line_crc_checker #(
  parameter int LINE_BYTES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire hlcc_pkg::in_beat_t  in_beat_i,
  output logic                     empty,
  input  wire logic                pop,
  output hlcc_pkg::out_beat_t      out_beat_o
);
  localparam int CharW = $bits(hlcc_pkg::char_t);
  localparam int ResW  = $bits(hlcc_pkg::out_beat_t);

  hlcc_pkg::char_t     fr_char, bk_char;
  hlcc_pkg::out_beat_t bk_res;
  logic                take_in, q_empty, bk_take, res_push, res_full;
  logic [CharW-1:0]    q_rdata;
  logic [ResW-1:0]     r_rdata;

  assign take_in = push && !full;

  hlcc_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take_in),
    .beat_i (in_beat_i),
    .char_o (fr_char)
  );

  hlcc_fifo #(.Width(CharW), .Depth(2)) u_char_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fr_char),
    .full_o  (full),
    .pop_i   (bk_take),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign bk_char = hlcc_pkg::char_t'(q_rdata);

  hlcc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (!q_empty),
    .char_i     (bk_char),
    .take_o     (bk_take),
    .res_push_o (res_push),
    .res_full_i (res_full),
    .res_o      (bk_res)
  );

  hlcc_fifo #(.Width(ResW), .Depth(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (bk_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (r_rdata),
    .empty_o (empty)
  );

  assign out_beat_o = hlcc_pkg::out_beat_t'(r_rdata);

  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_beat_o.heartbeat_ok == (out_beat_o.line_kind != hlcc_pkg::KIND_REJECT)))
    else $error("verdict flag disagrees with line kind");

  a_ok_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_beat_o.heartbeat_ok) |-> out_beat_o.link_valid)
    else $error("accepted heartbeat without link flag");

  a_no_lost_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_full) |-> 1'b0)
    else $error("verdict pushed into a full result queue");
endmodule
`default_nettype wire
